FILE: rtl/core/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg: shared definitions for the CRC-32 frame deframer
// Frame layout constants, status codes, register map and the byte-wide
// reflected CRC-32 update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

    // Frame layout
    localparam int unsigned HDR_BYTES           = 12;
    localparam int unsigned LENGTH_BITS_DEFAULT = 32;

    // Register map (word index)
    localparam int unsigned ADDR_BITS   = 3;
    localparam logic        REG_EXP_VER = 1'b0;
    localparam logic [31:0] EXP_VER_RST = 32'h0000_0001;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_VERSION   = 3'd1;
    localparam logic [2:0] ST_SHORT_HDR = 3'd2;
    localparam logic [2:0] ST_SHORT_BDY = 3'd3;
    localparam logic [2:0] ST_CRC_BAD   = 3'd4;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        logic [2:0]  status;
        logic [31:0] frame_id;
        logic [31:0] payload_length;
    } res_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/crc32_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// crc32_frame_deframer_unit: length-prefixed frame parser with CRC-32 check
// Parses back-to-back frames (12-byte header, payload, 4-byte CRC) from a
// byte stream, passes payload bytes through and reports each frame's end.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_*       in         s_valid / s_ready   s_in_byte, s_buffer_end
//  m_*       out        m_valid / m_ready   payload, frame_done, status, id, length
//  apb       in         psel/penable/pready expected_version at address 0
//
//  One byte per cycle while s_ready is high: the parse step (byte CRC update,
//  counter compare) sits between the state registers and a two-entry output
//  stage, so each result is registered into the output entry or the skid entry.
//  s_ready drops only while both output entries are full; bytes that give
//  no result still need a free skid entry. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_frame_deframer_unit #(
    parameter int unsigned LENGTH_BITS = cfd_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    // input byte channel
    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire  [7:0]                    s_in_byte,
    input  wire                           s_buffer_end,
    // result channel
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic                          m_payload_valid,
    output logic [7:0]                    m_payload_byte,
    output logic                          m_frame_done,
    output logic [2:0]                    m_status,
    output logic [31:0]                   m_frame_id,
    output logic [31:0]                   m_payload_length,
    // configuration port
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [cfd_pkg::ADDR_BITS-1:0] paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CHECK   = 2'd2;
    localparam logic [1:0] PH_DISCARD = 2'd3;

    localparam logic [LENGTH_BITS-1:0] HDR_LAST = LENGTH_BITS'(cfd_pkg::HDR_BYTES - 1);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [31:0] exp_ver_reg;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == cfd_pkg::REG_EXP_VER);
    assign prdata  = reg_sel ? exp_ver_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_ver_reg <= cfd_pkg::EXP_VER_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            exp_ver_reg <= pwdata;
        end
    end

    // ------------------------------------------------------------------
    // parser state
    // ------------------------------------------------------------------
    logic [1:0]             phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic [31:0]            ver_reg, ver_next;
    logic [31:0]            id_reg, id_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [31:0]            crc_reg, crc_next;
    logic [31:0]            rcv_reg, rcv_next;

    cfd_pkg::res_t          res;
    logic                   res_valid;
    logic                   s_fire;

    logic [31:0]            len_wide;
    logic [LENGTH_BITS-1:0] cnt_inc;
    logic                   finish;
    logic                   err;
    logic                   bad_crc;

    assign s_fire  = s_valid && s_ready;
    assign cnt_inc = cnt_reg + LENGTH_BITS'(1);

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        ver_next   = ver_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        rcv_next   = rcv_reg;
        res        = '0;
        finish     = 1'b0;
        err        = 1'b0;
        bad_crc    = 1'b0;
        len_wide   = 32'(len_reg);

        case (phase_reg)
            PH_HEADER: begin
                // place the byte into its header word
                case (cnt_reg[3:2])
                    2'd0:    ver_next[8*cnt_reg[1:0] +: 8] = s_in_byte;
                    2'd1:    id_next[8*cnt_reg[1:0] +: 8]  = s_in_byte;
                    default: len_wide[8*cnt_reg[1:0] +: 8] = s_in_byte;
                endcase
                len_next = len_wide[LENGTH_BITS-1:0];
                cnt_next = cnt_inc;
                if (cnt_reg == HDR_LAST) begin
                    res.frame_id       = id_next;
                    res.payload_length = 32'(len_next);
                    if (ver_next != exp_ver_reg) begin
                        res.frame_done = 1'b1;
                        res.status     = cfd_pkg::ST_VERSION;
                        finish         = 1'b1;
                        err            = 1'b1;
                    end else if (s_buffer_end) begin
                        res.frame_done = 1'b1;
                        res.status     = cfd_pkg::ST_SHORT_BDY;
                        finish         = 1'b1;
                        err            = 1'b1;
                    end else begin
                        phase_next = (len_next == '0) ? PH_CHECK : PH_PAYLOAD;
                        cnt_next   = '0;
                    end
                end else if (s_buffer_end) begin
                    res.frame_done = 1'b1;
                    res.status     = cfd_pkg::ST_SHORT_HDR;
                    finish         = 1'b1;
                    err            = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = s_in_byte;
                crc_next          = cfd_pkg::crc32_byte(crc_reg, s_in_byte);
                cnt_next          = cnt_inc;
                if (s_buffer_end) begin
                    res.frame_done     = 1'b1;
                    res.status         = cfd_pkg::ST_SHORT_BDY;
                    res.frame_id       = id_reg;
                    res.payload_length = 32'(len_reg);
                    finish             = 1'b1;
                    err                = 1'b1;
                end else if (cnt_inc == len_reg) begin
                    phase_next = PH_CHECK;
                    cnt_next   = '0;
                end
            end
            PH_CHECK: begin
                rcv_next[8*cnt_reg[1:0] +: 8] = s_in_byte;
                cnt_next = cnt_inc;
                if (cnt_reg[1:0] == 2'd3) begin
                    bad_crc            = (rcv_next != ~crc_reg);
                    res.frame_done     = 1'b1;
                    res.status         = bad_crc ? cfd_pkg::ST_CRC_BAD : cfd_pkg::ST_OK;
                    res.frame_id       = id_reg;
                    res.payload_length = 32'(len_reg);
                    finish             = 1'b1;
                    err                = bad_crc;
                end else if (s_buffer_end) begin
                    res.frame_done     = 1'b1;
                    res.status         = cfd_pkg::ST_SHORT_BDY;
                    res.frame_id       = id_reg;
                    res.payload_length = 32'(len_reg);
                    finish             = 1'b1;
                    err                = 1'b1;
                end
            end
            default: begin
                // drop bytes until the buffer ends
                if (s_buffer_end) begin
                    finish = 1'b1;
                end
            end
        endcase

        // restart or discard to buffer end; header words overwritten byte by byte
        if (finish) begin
            cnt_next   = '0;
            crc_next   = cfd_pkg::CRC_INIT;
            phase_next = (err && !s_buffer_end) ? PH_DISCARD : PH_HEADER;
        end

        res_valid = res.payload_valid || res.frame_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= '0;
            crc_reg   <= cfd_pkg::CRC_INIT;
        end else if (s_fire) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ver_reg <= ver_next;
            id_reg  <= id_next;
            len_reg <= len_next;
            rcv_reg <= rcv_next;
        end
    end

    // ------------------------------------------------------------------
    // output register with skid entry
    // ------------------------------------------------------------------
    cfd_pkg::res_t out_reg, skid_reg;
    logic          out_valid_reg, skid_valid_reg;
    logic          pop, push;

    assign s_ready = !skid_valid_reg;
    assign pop     = out_valid_reg && m_ready;
    assign push    = s_fire && res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || pop) begin
            out_valid_reg <= push;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (!out_valid_reg || pop) begin
            if (push) begin
                out_reg <= res;
            end
        end else if (push) begin
            skid_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_payload_valid  = out_reg.payload_valid;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_frame_done     = out_reg.frame_done;
    assign m_status         = out_reg.status;
    assign m_frame_id       = out_reg.frame_id;
    assign m_payload_length = out_reg.payload_length;

endmodule

`default_nettype wire
